// ----- sv/xpr_pkg.sv -----
package xpr_pkg;

  localparam int unsigned FRAME_WIDTH_DEF  = 96;
  localparam int unsigned FRAME_HEIGHT_DEF = 84;

  localparam int unsigned IDX_W = 14;
  localparam int unsigned RUN_W = 5;

  localparam logic [7:0] HDR_END_BYTE = 8'hFF;

  localparam logic [1:0] KIND_PIXEL   = 2'd0;
  localparam logic [1:0] KIND_SET_END = 2'd1;
  localparam logic [1:0] KIND_TRUNC   = 2'd2;

  typedef struct packed {
    logic [1:0]       kind;
    logic [IDX_W-1:0] pixel_index;
    logic [3:0]       xor_first;
    logic [3:0]       xor_second;
    logic             out_of_frame;
  } result_t;

endpackage

// ----- sv/xpr_parse.sv -----
module xpr_parse #(
  parameter int unsigned FRAME_WIDTH  = xpr_pkg::FRAME_WIDTH_DEF,
  parameter int unsigned FRAME_HEIGHT = xpr_pkg::FRAME_HEIGHT_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [7:0]      data_byte,
  input  logic            block_end,
  output logic            res_valid,
  output xpr_pkg::result_t res
);

  localparam int unsigned PixCount = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int unsigned CMP_W    = ($clog2(PixCount + 1) > xpr_pkg::IDX_W) ?
                                     $clog2(PixCount + 1) + 1 : xpr_pkg::IDX_W + 1;

  typedef enum logic [1:0] {
    PH_LOW  = 2'd0,
    PH_HIGH = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  phase_t                         phase_r, phase_nxt;
  logic [7:0]                     hdr_low_r, hdr_low_nxt;
  logic [xpr_pkg::RUN_W-1:0]      left_r, left_nxt;
  logic [xpr_pkg::IDX_W-1:0]      idx_r, idx_nxt;
  logic [xpr_pkg::RUN_W-1:0]      remaining;
  logic                           oof;

  assign remaining = left_r - xpr_pkg::RUN_W'(1);
  assign oof = (CMP_W'(idx_r) + CMP_W'(1)) >= CMP_W'(PixCount);

  always_comb begin
    phase_nxt   = phase_r;
    hdr_low_nxt = hdr_low_r;
    left_nxt    = left_r;
    idx_nxt     = idx_r;
    res_valid   = 1'b0;
    res         = '0;
    case (phase_r)
      PH_HIGH: begin
        if (hdr_low_r == xpr_pkg::HDR_END_BYTE && data_byte == xpr_pkg::HDR_END_BYTE) begin
          res_valid = 1'b1;
          res.kind  = xpr_pkg::KIND_SET_END;
          phase_nxt = PH_LOW;
          hdr_low_nxt = '0;
          left_nxt  = '0;
          idx_nxt   = '0;
        end else if (block_end) begin
          res_valid = 1'b1;
          res.kind  = xpr_pkg::KIND_TRUNC;
          phase_nxt = PH_LOW;
          hdr_low_nxt = '0;
          left_nxt  = '0;
          idx_nxt   = '0;
        end else begin
          left_nxt  = {1'b0, data_byte[7:4]} + xpr_pkg::RUN_W'(1);
          idx_nxt   = {1'b0, data_byte[3:0], hdr_low_r, 1'b0};
          phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        res_valid = 1'b1;
        if (block_end && remaining != '0) begin
          res.kind = xpr_pkg::KIND_TRUNC;
        end else begin
          res.kind         = xpr_pkg::KIND_PIXEL;
          res.pixel_index  = idx_r;
          res.xor_first    = data_byte[7:4];
          res.xor_second   = data_byte[3:0];
          res.out_of_frame = oof;
        end
        if (block_end || remaining == '0) begin
          phase_nxt   = PH_LOW;
          hdr_low_nxt = '0;
          left_nxt    = '0;
          idx_nxt     = '0;
        end else begin
          left_nxt = remaining;
          idx_nxt  = idx_r + xpr_pkg::IDX_W'(2);
        end
      end
      default: begin
        if (block_end) begin
          res_valid   = 1'b1;
          res.kind    = xpr_pkg::KIND_TRUNC;
          phase_nxt   = PH_LOW;
          hdr_low_nxt = '0;
          left_nxt    = '0;
          idx_nxt     = '0;
        end else begin
          hdr_low_nxt = data_byte;
          phase_nxt   = PH_HIGH;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_LOW;
      hdr_low_r <= '0;
      left_r    <= '0;
      idx_r     <= '0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      hdr_low_r <= hdr_low_nxt;
      left_r    <= left_nxt;
      idx_r     <= idx_nxt;
    end
  end

endmodule

// ----- sv/xor_patch_record_parser.sv -----
// Channel  Direction  Handshake           Beat payload
// in_      input      in_valid/in_stall   data_byte, block_end
// out_     output     out_valid/out_stall kind, pixel_index, xor_first, xor_second, out_of_frame
//
// One input beat per cycle while in_stall is low; a result leaves from the output
// register. A byte's work is one pass of the parse logic into the output register;
// a skid register holds a second result while out_stall is high.
// in_stall rises only when both output and skid registers are full.
// rst_n is synchronous; it clears the parser state and the valid flags of both
// result registers.
module xor_patch_record_parser #(
  parameter int unsigned FRAME_WIDTH  = xpr_pkg::FRAME_WIDTH_DEF,
  parameter int unsigned FRAME_HEIGHT = xpr_pkg::FRAME_HEIGHT_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                in_data_byte,
  input  logic                      in_block_end,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                out_kind,
  output logic [xpr_pkg::IDX_W-1:0] out_pixel_index,
  output logic [3:0]                out_xor_first,
  output logic [3:0]                out_xor_second,
  output logic                      out_out_of_frame
);

  logic              accept;
  logic              take;
  logic              res_valid;
  logic              res_v;
  xpr_pkg::result_t  res;
  xpr_pkg::result_t  main_r;
  xpr_pkg::result_t  skid_r;
  logic              main_valid_r;
  logic              skid_valid_r;

  assign in_stall = skid_valid_r;
  assign accept   = in_valid && !skid_valid_r;
  assign take     = main_valid_r && !out_stall;
  assign res_v    = accept && res_valid;

  xpr_parse #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT)
  ) u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .data_byte(in_data_byte),
    .block_end(in_block_end),
    .res_valid(res_valid),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (take) begin
      if (skid_valid_r) begin
        main_r       <= skid_r;
        skid_valid_r <= 1'b0;
      end else begin
        main_r       <= res;
        main_valid_r <= res_v;
      end
    end else if (!main_valid_r) begin
      main_r       <= res;
      main_valid_r <= res_v;
    end else if (res_v) begin
      skid_r       <= res;
      skid_valid_r <= 1'b1;
    end
  end

  assign out_valid        = main_valid_r;
  assign out_kind         = main_r.kind;
  assign out_pixel_index  = main_r.pixel_index;
  assign out_xor_first    = main_r.xor_first;
  assign out_xor_second   = main_r.xor_second;
  assign out_out_of_frame = main_r.out_of_frame;

  a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid register full while output register empty");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_stall))
    else $error("skid register filled without a stalled output");

  a_marker_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != xpr_pkg::KIND_PIXEL) |->
      (out_pixel_index == '0 && !out_out_of_frame && out_xor_first == '0))
    else $error("marker result carries pixel fields");

endmodule
